@@ hdl/tlws_pkg.sv @@
// shared types, widths and constants for the triangle lfo and window sweep block
package tlws_pkg;

  localparam int unsigned LEVEL_BITS = 10;
  localparam int unsigned DRONE_W    = 7;
  localparam int unsigned PERIOD_W   = 12;
  localparam int unsigned MINUTES_W  = 11;
  localparam int unsigned WIN_W      = 13;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 13;

  localparam int unsigned PHASE_W   = 30;
  localparam int unsigned SPAN_W    = 19;
  localparam int unsigned MUL_A_W   = 30;
  localparam int unsigned MUL_B_W   = 19;
  localparam int unsigned PROD_W    = MUL_A_W + MUL_B_W;
  localparam int unsigned LVL_PROD_W = 40;
  localparam int unsigned DIV_W     = 30;
  localparam int unsigned REM_W     = 19;
  localparam int unsigned ITER_W    = 4;
  localparam int unsigned TICK_W    = 24;
  localparam int unsigned LVL_QBITS = 12;

  localparam logic [WIN_W-1:0]   IMAGE_COUNT_MAX = 13'd4096;
  localparam logic [WIN_W-1:0]   WIN_MAX         = 13'h1FFF;
  localparam logic [WIN_W-1:0]   SLOW_SCALE      = 13'd6000;
  localparam logic [WIN_W-1:0]   FAST_SCALE      = 13'd2000;
  localparam logic [6:0]         TICKS_PER_S     = 7'd100;

  // radix-4 divider iterations per division kind
  localparam logic [ITER_W-1:0]  LVL_ITERS = 4'd6;
  localparam logic [ITER_W-1:0]  RLD_ITERS = 4'd15;
  localparam logic [ITER_W-1:0]  WIN_ITERS = 4'd12;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DRONE_MIN           = 3'd0,
    CFG_DRONE_MAX           = 3'd1,
    CFG_DRONE_PERIOD_S      = 3'd2,
    CFG_COLOUR_MIN          = 3'd3,
    CFG_COLOUR_MAX          = 3'd4,
    CFG_COLOUR_PERIOD_S     = 3'd5,
    CFG_WINDOW_SWEEP_MIN    = 3'd6,
    CFG_WINDOW_TARGET_WIDTH = 3'd7
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'd0,
    ST_L_INIT = 4'd1,
    ST_L_SPAN = 4'd2,
    ST_L_PROD = 4'd3,
    ST_L_DIV  = 4'd4,
    ST_L_RMUL = 4'd5,
    ST_L_RDIV = 4'd6,
    ST_W_INIT = 4'd7,
    ST_W_MUL  = 4'd8,
    ST_W_DIV  = 4'd9,
    ST_DONE   = 4'd10
  } seq_state_e;

  typedef struct packed {
    logic [DRONE_W-1:0]    drone_min;
    logic [DRONE_W-1:0]    drone_max;
    logic [PERIOD_W-1:0]   drone_period_s;
    logic [LEVEL_BITS-1:0] colour_min;
    logic [LEVEL_BITS-1:0] colour_max;
    logic [PERIOD_W-1:0]   colour_period_s;
    logic [MINUTES_W-1:0]  window_sweep_minutes;
    logic [WIN_W-1:0]      window_target_width;
  } cfg_t;

  typedef struct packed {
    logic [DRONE_W-1:0]    drone_level;
    logic [LEVEL_BITS-1:0] colour_level;
    logic [WIN_W-1:0]      window_low;
    logic [WIN_W-1:0]      window_high;
  } res_t;

  typedef struct packed {
    logic              start;
    logic [ITER_W-1:0] iters;
    logic [REM_W-1:0]  divisor;
    logic [REM_W-1:0]  rem_init;
    logic [DIV_W-1:0]  dividend;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quotient;
  } div_rsp_t;

endpackage

@@ hdl/tlws_if.sv @@
// valid/ready channel interfaces for tick words and result words
interface tlws_in_if;
  import tlws_pkg::*;
  logic             valid;
  logic             ready;
  logic [WIN_W-1:0] image_count;
  modport source (output valid, output image_count, input ready);
  modport sink (input valid, input image_count, output ready);
endinterface

interface tlws_out_if;
  import tlws_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [DRONE_W-1:0]    drone_level;
  logic [LEVEL_BITS-1:0] colour_level;
  logic [WIN_W-1:0]      window_low;
  logic [WIN_W-1:0]      window_high;
  modport source (output valid, output drone_level, output colour_level,
                  output window_low, output window_high, input ready);
  modport sink (input valid, input drone_level, input colour_level,
                input window_low, input window_high, output ready);
endinterface

@@ hdl/tlws_div.sv @@
// shared radix-4 restoring divider, two quotient bits per cycle
module tlws_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  tlws_pkg::div_req_t req_i,
  output tlws_pkg::div_rsp_t rsp_o
);
  import tlws_pkg::*;

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [ITER_W-1:0] cnt_q, cnt_d;
  logic [REM_W-1:0]  rem_q, rem_d;
  logic [DIV_W-1:0]  sh_q, sh_d;
  logic [REM_W-1:0]  dvs_q, dvs_d;

  logic [REM_W:0]    t1, t2;
  logic [REM_W-1:0]  r1, r2;
  logic              q1, q2;

  always_comb begin
    t1 = {rem_q, sh_q[DIV_W-1]};
    q1 = (t1 >= {1'b0, dvs_q});
    r1 = q1 ? REM_W'(t1 - {1'b0, dvs_q}) : t1[REM_W-1:0];
    t2 = {r1, sh_q[DIV_W-2]};
    q2 = (t2 >= {1'b0, dvs_q});
    r2 = q2 ? REM_W'(t2 - {1'b0, dvs_q}) : t2[REM_W-1:0];
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    sh_d   = sh_q;
    dvs_d  = dvs_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = req_i.iters;
      rem_d  = req_i.rem_init;
      sh_d   = req_i.dividend;
      dvs_d  = req_i.divisor;
    end else if (busy_q) begin
      rem_d = r2;
      sh_d  = {sh_q[DIV_W-3:0], q1, q2};
      cnt_d = cnt_q - ITER_W'(1);
      if (cnt_q == ITER_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    sh_q  <= sh_d;
    dvs_q <= dvs_d;
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = sh_q;

endmodule

@@ hdl/tlws_seq.sv @@
// sequencer: lfo and window state, shared multiplier, divider control
module tlws_seq (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic [tlws_pkg::WIN_W-1:0]      icount_i,
  input  tlws_pkg::cfg_t                  cfg_i,
  input  logic                            out_free_i,
  output logic                            idle_o,
  output logic                            res_valid_o,
  output tlws_pkg::res_t                  res_o,
  output tlws_pkg::div_req_t              div_req_o,
  input  tlws_pkg::div_rsp_t              div_rsp_i
);
  import tlws_pkg::*;

  seq_state_e state_q, state_d;
  logic                  sel_q, sel_d;
  logic [WIN_W-1:0]      icnt_q, icnt_d;
  logic [SPAN_W-1:0]     span_q, span_d;
  logic                  ovf_q, ovf_d;
  logic                  above_q, above_d;
  logic [PROD_W-1:0]     prod_q;
  logic [MUL_A_W-1:0]    mul_a;
  logic [MUL_B_W-1:0]    mul_b;

  logic [PHASE_W-1:0]    d_phase_q, d_phase_d, c_phase_q, c_phase_d;
  logic                  d_rising_q, d_rising_d, c_rising_q, c_rising_d;
  logic [DRONE_W-1:0]    dl_q, dl_d;
  logic [LEVEL_BITS-1:0] cl_q, cl_d;

  logic [TICK_W-1:0]     tick_q, tick_d;
  logic [WIN_W-1:0]      width_q, width_d, wlow_q, wlow_d, whigh_q, whigh_d;
  logic                  wback_q, wback_d;

  // selected lfo
  logic [LEVEL_BITS-1:0] lo, hi, delta, level_plain;
  logic [PERIOD_W-1:0]   per;
  logic [PHASE_W-1:0]    phase, p, p_mag;
  logic                  rising, p_neg, above, below;
  logic [LVL_QBITS-1:0]  lvl_q;

  logic                  lvl_we, ph_we, rise_val, lfo_next;
  logic [LEVEL_BITS-1:0] lvl_val;
  logic [PHASE_W-1:0]    ph_val;

  // window step
  logic [TICK_W-1:0]     tc1, rate;
  logic [WIN_W-1:0]      wscale, width_inc, width_n, low_n, high_n;
  logic [WIN_W:0]        hi_sum;
  logic                  wback_n;

  always_comb begin
    lo     = sel_q ? cfg_i.colour_min : LEVEL_BITS'(cfg_i.drone_min);
    hi     = sel_q ? cfg_i.colour_max : LEVEL_BITS'(cfg_i.drone_max);
    per    = sel_q ? cfg_i.colour_period_s : cfg_i.drone_period_s;
    phase  = sel_q ? c_phase_q : d_phase_q;
    rising = sel_q ? c_rising_q : d_rising_q;
    p      = phase + (rising ? PHASE_W'(1) : {PHASE_W{1'b1}});
    p_neg  = p[PHASE_W-1];
    p_mag  = p_neg ? (~p + PHASE_W'(1)) : p;
    delta  = hi - lo;
    lvl_q  = div_rsp_i.quotient[LVL_QBITS-1:0];
    above  = !p_neg && (ovf_q || (lvl_q > LVL_QBITS'(hi)));
    below  = p_neg ? (ovf_q || (lvl_q != '0) || (lo != '0))
                   : (!ovf_q && (lvl_q < LVL_QBITS'(lo)));
    level_plain = p_neg ? '0 : lvl_q[LEVEL_BITS-1:0];
  end

  always_comb begin
    wscale    = wback_q ? FAST_SCALE : SLOW_SCALE;
    rate      = div_rsp_i.quotient[TICK_W-1:0];
    tc1       = tick_q + TICK_W'(1);
    width_inc = width_q + WIN_W'(1);
    hi_sum    = {1'b0, wlow_q} + {1'b0, width_inc};
    width_n   = width_q;
    low_n     = wlow_q;
    high_n    = whigh_q;
    wback_n   = wback_q;
    if (width_q < cfg_i.window_target_width) begin
      width_n = width_inc;
      high_n  = (hi_sum > {1'b0, WIN_MAX}) ? WIN_MAX : hi_sum[WIN_W-1:0];
    end else begin
      if (({1'b0, whigh_q} + (WIN_W+1)'(1)) <= {1'b0, icnt_q}) begin
        high_n = whigh_q + WIN_W'(1);
      end
      if ((({1'b0, wlow_q} + {1'b0, width_q}) < {1'b0, icnt_q}) && !wback_q) begin
        low_n = wlow_q + WIN_W'(1);
      end else begin
        wback_n = 1'b1;
      end
    end
    if (wback_n && (low_n != '0)) begin
      low_n = low_n - WIN_W'(1);
    end
  end

  always_comb begin
    state_d    = state_q;
    sel_d      = sel_q;
    icnt_d     = icnt_q;
    span_d     = span_q;
    ovf_d      = ovf_q;
    above_d    = above_q;
    d_phase_d  = d_phase_q;
    c_phase_d  = c_phase_q;
    d_rising_d = d_rising_q;
    c_rising_d = c_rising_q;
    dl_d       = dl_q;
    cl_d       = cl_q;
    tick_d     = tick_q;
    width_d    = width_q;
    wlow_d     = wlow_q;
    whigh_d    = whigh_q;
    wback_d    = wback_q;
    mul_a      = '0;
    mul_b      = '0;
    div_req_o  = '0;
    idle_o     = 1'b0;
    res_valid_o = 1'b0;
    lvl_we     = 1'b0;
    lvl_val    = '0;
    ph_we      = 1'b0;
    ph_val     = p;
    rise_val   = rising;
    lfo_next   = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        idle_o = 1'b1;
        if (start_i) begin
          icnt_d  = (icount_i > IMAGE_COUNT_MAX) ? IMAGE_COUNT_MAX : icount_i;
          sel_d   = 1'b0;
          state_d = ST_L_INIT;
        end
      end
      ST_L_INIT: begin
        if (per == '0) begin
          lvl_we   = 1'b1;
          lfo_next = 1'b1;
        end else if (hi <= lo) begin
          lvl_we   = 1'b1;
          lvl_val  = lo;
          lfo_next = 1'b1;
        end else begin
          mul_a   = MUL_A_W'(per);
          mul_b   = MUL_B_W'(TICKS_PER_S);
          state_d = ST_L_SPAN;
        end
      end
      ST_L_SPAN: begin
        span_d  = prod_q[SPAN_W-1:0];
        mul_a   = p_mag;
        mul_b   = MUL_B_W'(delta);
        state_d = ST_L_PROD;
      end
      ST_L_PROD: begin
        ovf_d = prod_q[LVL_PROD_W-1:0] >= {9'b0, span_q, {LVL_QBITS{1'b0}}};
        div_req_o.start    = 1'b1;
        div_req_o.iters    = LVL_ITERS;
        div_req_o.divisor  = span_q;
        div_req_o.rem_init = prod_q[LVL_QBITS+REM_W-1:LVL_QBITS];
        div_req_o.dividend = {prod_q[LVL_QBITS-1:0], {(DIV_W-LVL_QBITS){1'b0}}};
        state_d = ST_L_DIV;
      end
      ST_L_DIV: begin
        if (div_rsp_i.done) begin
          if (above || below) begin
            above_d = above;
            mul_a   = MUL_A_W'(above ? hi : lo);
            mul_b   = span_q;
            state_d = ST_L_RMUL;
          end else begin
            lvl_we   = 1'b1;
            lvl_val  = level_plain;
            ph_we    = 1'b1;
            lfo_next = 1'b1;
          end
        end
      end
      ST_L_RMUL: begin
        div_req_o.start    = 1'b1;
        div_req_o.iters    = RLD_ITERS;
        div_req_o.divisor  = REM_W'(delta);
        div_req_o.rem_init = '0;
        div_req_o.dividend = prod_q[DIV_W-1:0];
        state_d = ST_L_RDIV;
      end
      ST_L_RDIV: begin
        if (div_rsp_i.done) begin
          lvl_we   = 1'b1;
          lvl_val  = above_q ? hi : lo;
          ph_we    = 1'b1;
          ph_val   = above_q ? (div_rsp_i.quotient - PHASE_W'(1)) : div_rsp_i.quotient;
          rise_val = !above_q;
          lfo_next = 1'b1;
        end
      end
      ST_W_INIT: begin
        if (cfg_i.window_sweep_minutes == '0) begin
          wlow_d  = '0;
          whigh_d = icnt_q;
          width_d = WIN_W'(1);
          wback_d = 1'b0;
          state_d = ST_DONE;
        end else if (icnt_q == '0) begin
          state_d = ST_DONE;
        end else begin
          mul_a   = MUL_A_W'(wscale);
          mul_b   = MUL_B_W'(cfg_i.window_sweep_minutes);
          state_d = ST_W_MUL;
        end
      end
      ST_W_MUL: begin
        div_req_o.start    = 1'b1;
        div_req_o.iters    = WIN_ITERS;
        div_req_o.divisor  = REM_W'(icnt_q);
        div_req_o.rem_init = '0;
        div_req_o.dividend = {prod_q[TICK_W-1:0], {(DIV_W-TICK_W){1'b0}}};
        state_d = ST_W_DIV;
      end
      ST_W_DIV: begin
        if (div_rsp_i.done) begin
          if (tc1 <= rate) begin
            tick_d = tc1;
          end else begin
            tick_d  = '0;
            width_d = width_n;
            wlow_d  = low_n;
            whigh_d = high_n;
            wback_d = wback_n;
          end
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free_i) begin
          res_valid_o = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (lvl_we) begin
      if (sel_q) cl_d = lvl_val;
      else       dl_d = lvl_val[DRONE_W-1:0];
    end
    if (ph_we) begin
      if (sel_q) begin
        c_phase_d  = ph_val;
        c_rising_d = rise_val;
      end else begin
        d_phase_d  = ph_val;
        d_rising_d = rise_val;
      end
    end
    if (lfo_next) begin
      if (sel_q) begin
        state_d = ST_W_INIT;
      end else begin
        sel_d   = 1'b1;
        state_d = ST_L_INIT;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      sel_q      <= 1'b0;
      d_phase_q  <= '0;
      c_phase_q  <= '0;
      d_rising_q <= 1'b1;
      c_rising_q <= 1'b1;
      tick_q     <= '0;
      width_q    <= WIN_W'(1);
      wlow_q     <= '0;
      whigh_q    <= '0;
      wback_q    <= 1'b0;
    end else begin
      state_q    <= state_d;
      sel_q      <= sel_d;
      d_phase_q  <= d_phase_d;
      c_phase_q  <= c_phase_d;
      d_rising_q <= d_rising_d;
      c_rising_q <= c_rising_d;
      tick_q     <= tick_d;
      width_q    <= width_d;
      wlow_q     <= wlow_d;
      whigh_q    <= whigh_d;
      wback_q    <= wback_d;
    end
  end

  always_ff @(posedge clk_i) begin
    icnt_q  <= icnt_d;
    span_q  <= span_d;
    ovf_q   <= ovf_d;
    above_q <= above_d;
    dl_q    <= dl_d;
    cl_q    <= cl_d;
    prod_q  <= PROD_W'(mul_a) * PROD_W'(mul_b);
  end

  assign res_o.drone_level  = dl_q;
  assign res_o.colour_level = cl_q;
  assign res_o.window_low   = wlow_q;
  assign res_o.window_high  = whigh_q;

endmodule

@@ hdl/triangle_lfo_and_window_sweep.sv @@
// top level: config registers, tick channel, result register, sequencer and divider
// per tick the drone lfo, then the colour lfo, then the window step run on the shared divider
// each lfo does two multiplies and a divide, plus a reload multiply and divide on a bound,
// the window a multiply and a divide; a disabled sweep skips its divide; ticks are taken one
// at a time, and a finished word waits in the output register while the next tick is taken
// reset: config zero, lfo phases zero and rising, window width one, no clearing pass
module triangle_lfo_and_window_sweep (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  tlws_in_if.sink                        in_i,
  tlws_out_if.source                     out_o,
  input  logic                           cfg_we_i,
  input  logic [tlws_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [tlws_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import tlws_pkg::*;

  cfg_t     cfg_q, cfg_d;
  res_t     seq_res, out_res_q;
  logic     out_valid_q, out_valid_d;
  logic     out_free, seq_idle, seq_res_valid, start;
  div_req_t div_req;
  div_rsp_t div_rsp;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_DRONE_MIN:           cfg_d.drone_min            = cfg_data_i[DRONE_W-1:0];
        CFG_DRONE_MAX:           cfg_d.drone_max            = cfg_data_i[DRONE_W-1:0];
        CFG_DRONE_PERIOD_S:      cfg_d.drone_period_s       = cfg_data_i[PERIOD_W-1:0];
        CFG_COLOUR_MIN:          cfg_d.colour_min           = cfg_data_i[LEVEL_BITS-1:0];
        CFG_COLOUR_MAX:          cfg_d.colour_max           = cfg_data_i[LEVEL_BITS-1:0];
        CFG_COLOUR_PERIOD_S:     cfg_d.colour_period_s      = cfg_data_i[PERIOD_W-1:0];
        CFG_WINDOW_SWEEP_MIN:    cfg_d.window_sweep_minutes = cfg_data_i[MINUTES_W-1:0];
        CFG_WINDOW_TARGET_WIDTH: cfg_d.window_target_width  = cfg_data_i[WIN_W-1:0];
        default: cfg_d = cfg_q;
      endcase
    end
  end

  assign out_free = !out_valid_q || out_o.ready;
  assign start    = in_i.valid && in_i.ready;

  always_comb begin
    out_valid_d = out_valid_q;
    if (seq_res_valid) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cfg_q       <= cfg_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (seq_res_valid) begin
      out_res_q <= seq_res;
    end
  end

  tlws_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .icount_i    (in_i.image_count),
    .cfg_i       (cfg_q),
    .out_free_i  (out_free),
    .idle_o      (seq_idle),
    .res_valid_o (seq_res_valid),
    .res_o       (seq_res),
    .div_req_o   (div_req),
    .div_rsp_i   (div_rsp)
  );

  tlws_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign in_i.ready         = seq_idle;
  assign out_o.valid        = out_valid_q;
  assign out_o.drone_level  = out_res_q.drone_level;
  assign out_o.colour_level = out_res_q.colour_level;
  assign out_o.window_low   = out_res_q.window_low;
  assign out_o.window_high  = out_res_q.window_high;

endmodule

@@ hdl/tlws_chk.sv @@
// port-level checker for the sweep block and its bind
module tlws_chk (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            in_valid_i,
  input logic                            in_ready_i,
  input logic                            out_valid_i,
  input logic                            out_ready_i,
  input logic [tlws_pkg::DRONE_W-1:0]    drone_level_i,
  input logic [tlws_pkg::LEVEL_BITS-1:0] colour_level_i,
  input logic [tlws_pkg::WIN_W-1:0]      window_low_i,
  input logic [tlws_pkg::WIN_W-1:0]      window_high_i
);
  import tlws_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result word dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(drone_level_i) && $stable(colour_level_i) &&
                                    $stable(window_low_i) && $stable(window_high_i))
    else $error("result word changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("tick taken while previous tick still in work");

  a_result_frees_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $rose(in_ready_i))
    else $error("result issued without returning to idle");

endmodule

bind triangle_lfo_and_window_sweep tlws_chk u_tlws_chk (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_i.valid),
  .in_ready_i     (in_i.ready),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .drone_level_i  (out_o.drone_level),
  .colour_level_i (out_o.colour_level),
  .window_low_i   (out_o.window_low),
  .window_high_i  (out_o.window_high)
);
